// ===== rtl/ets_pkg.sv =====
// ----------------------------------------------------------------------------
// Epoch seconds to calendar: shared package
// Command codes, status bundle and calendar constants shared by the
// controller and the datapath.
// ----------------------------------------------------------------------------
package ets_pkg;

    localparam logic [31:0] SECS_PER_DAY         = 32'd86400;
    localparam logic [31:0] SECS_PER_COMMON_YEAR = 32'd31536000;
    localparam logic [31:0] SECS_PER_LEAP_YEAR   = 32'd31622400;
    localparam logic [6:0]  BASE_YEAR_IN_CENTURY = 7'd70;
    localparam logic [4:0]  BASE_CENTURY         = 5'd19;
    localparam logic [6:0]  LAST_YEAR_IN_CENTURY = 7'd99;
    localparam logic [3:0]  LAST_MONTH_INDEX     = 4'd11;
    localparam logic [3:0]  FEBRUARY_INDEX       = 4'd1;
    localparam logic [16:0] OFFSET_RESET         = 17'd28800;
    localparam logic [16:0] HOUR_RECIPROCAL      = 17'd74566;
    localparam int          HOUR_SHIFT           = 28;
    localparam logic [11:0] SECS_PER_HOUR        = 12'd3600;
    localparam logic [14:0] MINUTE_RECIPROCAL    = 15'd17477;
    localparam int          MINUTE_SHIFT         = 20;
    localparam logic [5:0]  SECS_PER_MINUTE      = 6'd60;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_YEAR,
        CMD_MONTH,
        CMD_DAY,
        CMD_HOUR_MUL,
        CMD_HOUR_SUB,
        CMD_MIN_MUL,
        CMD_MIN_SUB
    } cmd_t;

    typedef struct packed {
        logic year_done;
        logic month_done;
        logic day_done;
    } status_t;

    function automatic logic [31:0] month_secs(input logic [3:0] month, input logic leap);
        logic [31:0] secs;
        case (month)
            4'd0:    secs = 32'd2678400;
            4'd1:    secs = leap ? 32'd2505600 : 32'd2419200;
            4'd2:    secs = 32'd2678400;
            4'd3:    secs = 32'd2592000;
            4'd4:    secs = 32'd2678400;
            4'd5:    secs = 32'd2592000;
            4'd6:    secs = 32'd2678400;
            4'd7:    secs = 32'd2678400;
            4'd8:    secs = 32'd2592000;
            4'd9:    secs = 32'd2678400;
            4'd10:   secs = 32'd2592000;
            4'd11:   secs = 32'd2678400;
            default: secs = 32'd2678400;
        endcase
        return secs;
    endfunction

endpackage

// ===== rtl/ets_ctrl.sv =====
// ----------------------------------------------------------------------------
// Epoch seconds to calendar: controller
// Sequences the year, month and day passes and the hour and minute steps,
// and runs the handshakes on both channels.
// ----------------------------------------------------------------------------
module ets_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  ets_pkg::status_t status,
    output ets_pkg::cmd_t   cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_YEAR,
        ST_MONTH,
        ST_DAY,
        ST_HOUR_MUL,
        ST_HOUR_SUB,
        ST_MIN_MUL,
        ST_MIN_SUB,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = ets_pkg::CMD_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = ets_pkg::CMD_LOAD;
                    state_next = ST_YEAR;
                end
            end
            ST_YEAR:
            begin
                cmd = ets_pkg::CMD_YEAR;
                if (status.year_done)
                begin
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH:
            begin
                cmd = ets_pkg::CMD_MONTH;
                if (status.month_done)
                begin
                    state_next = ST_DAY;
                end
            end
            ST_DAY:
            begin
                cmd = ets_pkg::CMD_DAY;
                if (status.day_done)
                begin
                    state_next = ST_HOUR_MUL;
                end
            end
            ST_HOUR_MUL:
            begin
                cmd        = ets_pkg::CMD_HOUR_MUL;
                state_next = ST_HOUR_SUB;
            end
            ST_HOUR_SUB:
            begin
                cmd        = ets_pkg::CMD_HOUR_SUB;
                state_next = ST_MIN_MUL;
            end
            ST_MIN_MUL:
            begin
                cmd        = ets_pkg::CMD_MIN_MUL;
                state_next = ST_MIN_SUB;
            end
            ST_MIN_SUB:
            begin
                cmd        = ets_pkg::CMD_MIN_SUB;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_DONE);

endmodule

// ===== rtl/ets_dp.sv =====
// ----------------------------------------------------------------------------
// Epoch seconds to calendar: datapath
// Holds the zone offset, the remaining seconds and the calendar counters,
// and performs one step of the conversion for each command.
// ----------------------------------------------------------------------------
module ets_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [16:0]      cfg_wr_data,
    input  logic [31:0]      epoch_seconds,
    input  ets_pkg::cmd_t    cmd,
    output ets_pkg::status_t status,
    output logic [4:0]       century,
    output logic [6:0]       year_in_century,
    output logic [3:0]       month_number,
    output logic [4:0]       day_of_month,
    output logic [4:0]       hour_of_day,
    output logic [5:0]       minute_of_hour,
    output logic [5:0]       second_of_minute
);

    logic [16:0] offset_reg;
    logic [31:0] rest_reg;
    logic [31:0] rest_next;
    logic [4:0]  century_reg;
    logic [4:0]  century_next;
    logic [6:0]  yic_reg;
    logic [6:0]  yic_next;
    logic [3:0]  month_reg;
    logic [3:0]  month_next;
    logic [4:0]  day_reg;
    logic [4:0]  day_next;
    logic [4:0]  hour_reg;
    logic [4:0]  hour_next;
    logic [5:0]  minute_reg;
    logic [5:0]  minute_next;
    logic [5:0]  second_reg;
    logic [5:0]  second_next;

    logic        leap;
    logic [31:0] year_len;
    logic [31:0] month_len;
    logic [33:0] hour_prod;
    logic [16:0] hour_secs;
    logic [26:0] minute_prod;
    logic [11:0] minute_secs;
    logic [11:0] second_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= ets_pkg::OFFSET_RESET;
        end
        else if (cfg_wr_en)
        begin
            offset_reg <= cfg_wr_data;
        end
    end

    // A century year is a leap year only when the century is a multiple of four.
    assign leap = ((yic_reg[1:0] == 2'b00) && (yic_reg != 7'd0))
                || ((yic_reg == 7'd0) && (century_reg[1:0] == 2'b00));

    assign year_len  = leap ? ets_pkg::SECS_PER_LEAP_YEAR : ets_pkg::SECS_PER_COMMON_YEAR;
    assign month_len = ets_pkg::month_secs(month_reg, leap && (month_reg == ets_pkg::FEBRUARY_INDEX));

    assign status.year_done  = (rest_reg < year_len);
    assign status.month_done = (month_reg == ets_pkg::LAST_MONTH_INDEX) || (rest_reg < month_len);
    assign status.day_done   = (rest_reg < ets_pkg::SECS_PER_DAY);

    assign hour_prod   = {17'd0, rest_reg[16:0]} * {17'd0, ets_pkg::HOUR_RECIPROCAL};
    assign hour_secs   = {12'd0, hour_reg} * {5'd0, ets_pkg::SECS_PER_HOUR};
    assign minute_prod = {15'd0, rest_reg[11:0]} * {12'd0, ets_pkg::MINUTE_RECIPROCAL};
    assign minute_secs = {6'd0, minute_reg} * {6'd0, ets_pkg::SECS_PER_MINUTE};
    assign second_full = rest_reg[11:0] - minute_secs;

    always_comb
    begin
        rest_next    = rest_reg;
        century_next = century_reg;
        yic_next     = yic_reg;
        month_next   = month_reg;
        day_next     = day_reg;
        hour_next    = hour_reg;
        minute_next  = minute_reg;
        second_next  = second_reg;
        case (cmd)
            ets_pkg::CMD_LOAD:
            begin
                rest_next    = epoch_seconds + {{15{offset_reg[16]}}, offset_reg};
                century_next = ets_pkg::BASE_CENTURY;
                yic_next     = ets_pkg::BASE_YEAR_IN_CENTURY;
                month_next   = 4'd0;
                day_next     = 5'd0;
            end
            ets_pkg::CMD_YEAR:
            begin
                if (!status.year_done)
                begin
                    rest_next = rest_reg - year_len;
                    if (yic_reg == ets_pkg::LAST_YEAR_IN_CENTURY)
                    begin
                        yic_next     = 7'd0;
                        century_next = century_reg + 5'd1;
                    end
                    else
                    begin
                        yic_next = yic_reg + 7'd1;
                    end
                end
            end
            ets_pkg::CMD_MONTH:
            begin
                if (!status.month_done)
                begin
                    rest_next  = rest_reg - month_len;
                    month_next = month_reg + 4'd1;
                end
            end
            ets_pkg::CMD_DAY:
            begin
                if (!status.day_done)
                begin
                    rest_next = rest_reg - ets_pkg::SECS_PER_DAY;
                    day_next  = day_reg + 5'd1;
                end
            end
            ets_pkg::CMD_HOUR_MUL:
            begin
                hour_next = hour_prod[ets_pkg::HOUR_SHIFT +: 5];
            end
            ets_pkg::CMD_HOUR_SUB:
            begin
                rest_next = {15'd0, rest_reg[16:0] - hour_secs};
            end
            ets_pkg::CMD_MIN_MUL:
            begin
                minute_next = minute_prod[ets_pkg::MINUTE_SHIFT +: 6];
            end
            ets_pkg::CMD_MIN_SUB:
            begin
                second_next = second_full[5:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rest_reg    <= rest_next;
        century_reg <= century_next;
        yic_reg     <= yic_next;
        month_reg   <= month_next;
        day_reg     <= day_next;
        hour_reg    <= hour_next;
        minute_reg  <= minute_next;
        second_reg  <= second_next;
    end

    assign century          = century_reg;
    assign year_in_century  = yic_reg;
    assign month_number     = month_reg + 4'd1;
    assign day_of_month     = day_reg + 5'd1;
    assign hour_of_day      = hour_reg;
    assign minute_of_hour   = minute_reg;
    assign second_of_minute = second_reg;

endmodule

// ===== rtl/epoch_seconds_to_calendar_top.sv =====
// ----------------------------------------------------------------------------
// Epoch seconds to calendar: top level
// Converts a count of seconds since 1970, shifted by a programmable zone
// offset, into local date and time.
// ----------------------------------------------------------------------------
// One word is converted at a time. The year pass takes away each whole year
// after 1970, the month pass each whole month before the date and the day
// pass each whole day before the date; these passes each take away one
// calendar unit per cycle, and the hour and minute steps follow. The longest
// conversion is that of the last day of 2105. The next word is accepted only
// once the result has been taken. The zone offset resets to 28800 seconds and
// should only be written while idle.
module epoch_seconds_to_calendar_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [16:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] epoch_seconds,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  century,
    output logic [6:0]  year_in_century,
    output logic [3:0]  month_number,
    output logic [4:0]  day_of_month,
    output logic [4:0]  hour_of_day,
    output logic [5:0]  minute_of_hour,
    output logic [5:0]  second_of_minute
);

    ets_pkg::cmd_t    cmd;
    ets_pkg::status_t status;

    ets_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    ets_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .epoch_seconds    (epoch_seconds),
        .cmd              (cmd),
        .status           (status),
        .century          (century),
        .year_in_century  (year_in_century),
        .month_number     (month_number),
        .day_of_month     (day_of_month),
        .hour_of_day      (hour_of_day),
        .minute_of_hour   (minute_of_hour),
        .second_of_minute (second_of_minute)
    );

endmodule

// ===== bench/epoch_seconds_to_calendar_top_test.sv =====
// ----------------------------------------------------------------------------
// Epoch seconds to calendar: testbench
// Drives timestamps through the converter under several zone offsets, with
// idle and stall patterns on both sides, and checks every date and time word
// that comes back against a calendar computed in the bench.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_top_test;

    localparam int LIMIT = 2000000;
    localparam int DAY = 86400;

    typedef struct packed {
        logic [4:0] century;
        logic [6:0] year_in_century;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } date_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [16:0] cfg_wr_data;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] epoch_seconds;
    logic        out_valid;
    logic        out_ready;
    logic [4:0]  century;
    logic [6:0]  year_in_century;
    logic [3:0]  month_number;
    logic [4:0]  day_of_month;
    logic [4:0]  hour_of_day;
    logic [5:0]  minute_of_hour;
    logic [5:0]  second_of_minute;

    int send_idle = 0;
    int recv_stall = 0;
    int hold_left = 0;
    int cycle_count = 0;

    epoch_seconds_to_calendar_top uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .epoch_seconds    (epoch_seconds),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .century          (century),
        .year_in_century  (year_in_century),
        .month_number     (month_number),
        .day_of_month     (day_of_month),
        .hour_of_day      (hour_of_day),
        .minute_of_hour   (minute_of_hour),
        .second_of_minute (second_of_minute)
    );

    function automatic bit is_leap(int unsigned yr);
        return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(int unsigned yr, int unsigned mo);
        case (mo)
            1: return is_leap(yr) ? 29 : 28;
            3, 5, 8, 10: return 30;
            default: return 31;
        endcase
    endfunction

    function automatic date_t civil_date(logic [31:0] stamp, logic [16:0] zone);
        logic [31:0] rest;
        int unsigned yr;
        int unsigned mo;
        int unsigned span;
        date_t d;
        rest = stamp + {{15{zone[16]}}, zone};
        yr = 1970;
        mo = 0;
        span = (is_leap(yr) ? 366 : 365) * DAY;
        while (rest >= span)
        begin
            rest -= span;
            yr++;
            span = (is_leap(yr) ? 366 : 365) * DAY;
        end
        while (mo < 11 && rest >= days_in_month(yr, mo) * DAY)
        begin
            rest -= days_in_month(yr, mo) * DAY;
            mo++;
        end
        d.century = 5'(yr / 100);
        d.year_in_century = 7'(yr % 100);
        d.month = 4'(mo + 1);
        d.day = 5'(rest / DAY + 1);
        d.hour = 5'((rest % DAY) / 3600);
        d.minute = 6'((rest % 3600) / 60);
        d.second = 6'(rest % 60);
        return d;
    endfunction

    // Timestamp whose local time is the given moment; month is counted from 0.
    function automatic logic [31:0] local_stamp(int unsigned yr, int unsigned mo,
                                                int unsigned day, int unsigned secs,
                                                logic [16:0] zone);
        longint total;
        int unsigned y;
        int unsigned m;
        int z;
        total = 0;
        for (y = 1970; y < yr; y++)
            total += (is_leap(y) ? 366 : 365) * DAY;
        for (m = 0; m < mo; m++)
            total += days_in_month(yr, m) * DAY;
        total += longint'(day - 1) * DAY + secs;
        z = $signed(zone);
        total -= z;
        return total[31:0];
    endfunction

    function automatic logic [31:0] pick_stamp(logic [16:0] zone);
        int unsigned yr;
        int unsigned mo;
        int unsigned day;
        int unsigned secs;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            8: return $urandom_range(0, 100000000);
            9: return 32'hFFFFFFFF - $urandom_range(0, 100000000);
            default:
            begin
                yr = $urandom_range(1970, 2106);
                mo = $urandom_range(0, 11);
                day = $urandom_range(0, 1) ? 1 : days_in_month(yr, mo);
                secs = $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(86397, 86399);
                return local_stamp(yr, mo, day, secs, zone);
            end
        endcase
    endfunction

    class calendar_scoreboard;
        date_t due_dates[$];
        logic [16:0] zone;
        int mismatches;

        function new();
            zone = ets_pkg::OFFSET_RESET;
            mismatches = 0;
        endfunction

        function void note_timestamp(logic [31:0] stamp);
            due_dates.push_back(civil_date(stamp, zone));
        endfunction

        task report(string note);
            $display("mismatch: %s", note);
            mismatches++;
        endtask

        task check_date(date_t got);
            date_t want;
            if (due_dates.size() == 0)
            begin
                report($sformatf("result word with none expected: %h", got));
                return;
            end
            want = due_dates.pop_front();
            if (got.century !== want.century)
                report($sformatf("century %0d, expected %0d", got.century, want.century));
            if (got.year_in_century !== want.year_in_century)
                report($sformatf("year_in_century %0d, expected %0d",
                                 got.year_in_century, want.year_in_century));
            if (got.month !== want.month)
                report($sformatf("month_number %0d, expected %0d", got.month, want.month));
            if (got.day !== want.day)
                report($sformatf("day_of_month %0d, expected %0d", got.day, want.day));
            if (got.hour !== want.hour)
                report($sformatf("hour_of_day %0d, expected %0d", got.hour, want.hour));
            if (got.minute !== want.minute)
                report($sformatf("minute_of_hour %0d, expected %0d", got.minute, want.minute));
            if (got.second !== want.second)
                report($sformatf("second_of_minute %0d, expected %0d",
                                 got.second, want.second));
        endtask
    endclass

    calendar_scoreboard sb = new();

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("epoch_seconds_to_calendar_top_test: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            sb.check_date({century, year_in_century, month_number, day_of_month,
                           hour_of_day, minute_of_hour, second_of_minute});
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_stall);
    end

    task send_word(logic [31:0] stamp);
        if ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle);
        end
        in_valid <= 1'b1;
        epoch_seconds <= stamp;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_timestamp(stamp);
    endtask

    task drain;
        in_valid <= 1'b0;
        while (sb.due_dates.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task set_zone(logic [16:0] zone);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= zone;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.zone = zone;
    endtask

    task run_phase(logic [16:0] zone, int sender_idle, int receiver_stall, int words,
                   int hold);
        int k;
        set_zone(zone);
        send_idle = sender_idle;
        recv_stall = receiver_stall;
        hold_left = hold;
        send_word(32'h0);
        send_word(32'hFFFFFFFF);
        for (k = 0; k < words; k++)
            send_word(pick_stamp(sb.zone));
        drain();
    endtask

    initial
    begin
        logic [31:0] opening[$];
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= 17'd0;
        in_valid <= 1'b0;
        epoch_seconds <= 32'd0;
        out_ready <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset offset still in force: edges of the range and the leap rules.
        opening = '{32'h0, 32'h1, 32'hFFFFFFFF, 32'hFFFFFFFE, 32'h7FFFFFFF, 32'h80000000,
                    local_stamp(1970, 0, 1, 0, sb.zone),
                    local_stamp(1972, 1, 28, 86399, sb.zone),
                    local_stamp(1972, 1, 29, 0, sb.zone),
                    local_stamp(1972, 2, 1, 0, sb.zone),
                    local_stamp(1999, 11, 31, 86399, sb.zone),
                    local_stamp(2000, 0, 1, 0, sb.zone),
                    local_stamp(2000, 1, 29, 43200, sb.zone),
                    local_stamp(2000, 11, 31, 86399, sb.zone),
                    local_stamp(2001, 0, 1, 0, sb.zone),
                    local_stamp(2100, 1, 28, 86399, sb.zone),
                    local_stamp(2100, 2, 1, 0, sb.zone),
                    local_stamp(2104, 1, 29, 3661, sb.zone),
                    local_stamp(2105, 11, 31, 86399, sb.zone),
                    local_stamp(2106, 1, 7, 52095, sb.zone)};
        foreach (opening[i])
            send_word(opening[i]);
        drain();

        run_phase(17'd0, 0, 0, 235, 0);
        run_phase(17'(-43200), 77, 0, 235, 0);
        run_phase(17'd50400, 0, 77, 235, 0);
        run_phase(17'h10000, 26, 26, 235, 0);
        run_phase(17'h0FFFF, 0, 0, 235, 600);
        run_phase(17'($urandom_range(0, 93600) - 43200), 77, 0, 235, 0);
        run_phase(17'($urandom), 0, 77, 235, 0);
        run_phase(17'd28800, 26, 26, 235, 0);

        repeat (200) @(posedge clk);
        if (sb.mismatches == 0)
            $display("epoch_seconds_to_calendar_top_test: PASS");
        else
            $display("epoch_seconds_to_calendar_top_test: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ets_pkg.sv
rtl/ets_ctrl.sv
rtl/ets_dp.sv
rtl/epoch_seconds_to_calendar_top.sv
bench/epoch_seconds_to_calendar_top_test.sv
